// File: rtl/yrp_pkg.sv
package yrp_pkg;

	// one rgb pixel, saturated bytes
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// coefficients and offsets in millionths
	localparam longint unsigned MicroRv = 64'd1402000;
	localparam longint unsigned MicroGu = 64'd344136;
	localparam longint unsigned MicroGv = 64'd714136;
	localparam longint unsigned MicroBu = 64'd1772000;
	localparam longint unsigned MicroOr = 64'd701000;
	localparam longint unsigned MicroOg = 64'd529136;
	localparam longint unsigned MicroOb = 64'd886000;

	// round a value in millionths to nearest at frac fraction bits
	function automatic longint unsigned qcoef(input longint unsigned micro, input int frac);
		return ((micro << frac) + 64'd500000) / 64'd1000000;
	endfunction

endpackage

// File: rtl/yrp_word_if.sv
interface yrp_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] packed_word;

	modport source (output valid, output packed_word, input ready);
	modport sink (input valid, input packed_word, output ready);
endinterface

// File: rtl/yrp_rgb_if.sv
interface yrp_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_first;
	logic [7:0] green_first;
	logic [7:0] blue_first;
	logic [7:0] red_second;
	logic [7:0] green_second;
	logic [7:0] blue_second;

	modport source (output valid, output red_first, output green_first, output blue_first,
		output red_second, output green_second, output blue_second, input ready);
	modport sink (input valid, input red_first, input green_first, input blue_first,
		input red_second, input green_second, input blue_second, output ready);
endinterface

// File: rtl/yrp_chroma.sv
module yrp_chroma #(
	parameter int COEFF_FRAC_BITS = 12
) (
	input  logic [7:0]                       u,
	input  logic [7:0]                       v,
	output logic signed [COEFF_FRAC_BITS+10:0] chroma_red,
	output logic signed [COEFF_FRAC_BITS+10:0] chroma_green,
	output logic signed [COEFF_FRAC_BITS+10:0] chroma_blue
);
	localparam int F  = COEFF_FRAC_BITS;
	localparam int SW = F + 11;
	localparam int PW = F + 9;

	// quantised coefficients, all below two
	localparam logic [F:0] K_RV = (F+1)'(yrp_pkg::qcoef(yrp_pkg::MicroRv, F));
	localparam logic [F:0] K_GU = (F+1)'(yrp_pkg::qcoef(yrp_pkg::MicroGu, F));
	localparam logic [F:0] K_GV = (F+1)'(yrp_pkg::qcoef(yrp_pkg::MicroGv, F));
	localparam logic [F:0] K_BU = (F+1)'(yrp_pkg::qcoef(yrp_pkg::MicroBu, F));

	// offsets scaled to the sum's units
	localparam logic signed [SW-1:0] OFF_R = SW'(yrp_pkg::qcoef(yrp_pkg::MicroOr, F) << 8);
	localparam logic signed [SW-1:0] OFF_G = SW'(yrp_pkg::qcoef(yrp_pkg::MicroOg, F) << 8);
	localparam logic signed [SW-1:0] OFF_B = SW'(yrp_pkg::qcoef(yrp_pkg::MicroOb, F) << 8);

	logic [PW-1:0] prod_rv;
	logic [PW-1:0] prod_gu;
	logic [PW-1:0] prod_gv;
	logic [PW-1:0] prod_bu;

	// constant multiplies, 8 bits by F+1 bits
	always_comb begin
		prod_rv = PW'(v) * PW'(K_RV);
		prod_gu = PW'(u) * PW'(K_GU);
		prod_gv = PW'(v) * PW'(K_GV);
		prod_bu = PW'(u) * PW'(K_BU);
	end

	// chroma terms shared by both pixels
	always_comb begin
		chroma_red   = $signed({2'b00, prod_rv}) - OFF_R;
		chroma_green = OFF_G - $signed({2'b00, prod_gu}) - $signed({2'b00, prod_gv});
		chroma_blue  = $signed({2'b00, prod_bu}) - OFF_B;
	end
endmodule

// File: rtl/yrp_lane.sv
module yrp_lane #(
	parameter int COEFF_FRAC_BITS = 12
) (
	input  logic [7:0]                         luma,
	input  logic                               colour_mode,
	input  logic signed [COEFF_FRAC_BITS+10:0] chroma_red,
	input  logic signed [COEFF_FRAC_BITS+10:0] chroma_green,
	input  logic signed [COEFF_FRAC_BITS+10:0] chroma_blue,
	output yrp_pkg::rgb_t                      pixel
);
	localparam int F  = COEFF_FRAC_BITS;
	localparam int SW = F + 11;
	localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);

	logic signed [SW-1:0] luma_scaled;
	logic signed [SW-1:0] sum_r;
	logic signed [SW-1:0] sum_g;
	logic signed [SW-1:0] sum_b;

	// round to nearest at F fraction bits and clamp to a byte
	function automatic logic [7:0] to_byte(input logic signed [SW-1:0] sum);
		logic [SW-1:0] rounded;
		logic [10:0]   whole;
		rounded = $unsigned(sum) + HALF;
		whole   = rounded[SW-1:F];
		if (sum[SW-1] || sum == '0) begin
			return 8'd0;
		end else if (whole > 11'd255) begin
			return 8'd255;
		end
		return whole[7:0];
	endfunction

	// luma aligned to the coefficient fraction
	assign luma_scaled = $signed({3'b000, luma, {F{1'b0}}});

	always_comb begin
		sum_r = luma_scaled + chroma_red;
		sum_g = luma_scaled + chroma_green;
		sum_b = luma_scaled + chroma_blue;
	end

	// colour conversion or luma replicated in grey mode
	always_comb begin
		if (colour_mode) begin
			pixel.red   = to_byte(sum_r);
			pixel.green = to_byte(sum_g);
			pixel.blue  = to_byte(sum_b);
		end else begin
			pixel.red   = luma;
			pixel.green = luma;
			pixel.blue  = luma;
		end
	end
endmodule

// File: rtl/yuyv_to_rgb_pair_core.sv
// yuyv to rgb pair converter
//
// yuv carries one packed 4:2:2 request per transfer: u in bits 7:0, first
// luma in 15:8, v in 23:16, second luma in 31:24. rgb returns one request
// per input request holding two pixels that share u and v. Both channels
// use valid/ready and move a request on a clock edge with both high.
// cfg_we writes cfg_wdata into the colour mode register (1: bt.601 full
// range conversion, 0: each luma copied to its three channels); write it
// only while no request is in flight.
// A request is registered in stage one and then in stage two, and rgb valid
// rises once stage two holds it. Stage one forms the shared chroma products,
// stage two runs two pixel lanes side by side and registers both pixels
// together. One request per cycle is sustained while rgb ready stays high.
// arst_n clears both stage valids and selects grey mode. When rgb stalls
// the output register holds its request and the pipeline keeps filling;
// yuv ready falls only once both stages are occupied.
module yuyv_to_rgb_pair_core #(
	parameter int COEFF_FRAC_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	yrp_word_if.sink         yuv,
	yrp_rgb_if.source        rgb
);
	localparam int SW = COEFF_FRAC_BITS + 11;

	logic                 colour_mode_q;
	logic                 valid_s1;
	logic                 mode_s1;
	logic [7:0]           y_first_s1;
	logic [7:0]           y_second_s1;
	logic signed [SW-1:0] cr_s1;
	logic signed [SW-1:0] cg_s1;
	logic signed [SW-1:0] cb_s1;
	logic                 valid_s2;
	yrp_pkg::rgb_t        first_s2;
	yrp_pkg::rgb_t        second_s2;

	logic signed [SW-1:0] chroma_red;
	logic signed [SW-1:0] chroma_green;
	logic signed [SW-1:0] chroma_blue;
	yrp_pkg::rgb_t        first_pixel;
	yrp_pkg::rgb_t        second_pixel;
	logic                 advance_s2;
	logic                 advance_s1;

	// stage handshake
	assign advance_s2 = !valid_s2 || rgb.ready;
	assign advance_s1 = !valid_s1 || advance_s2;
	assign yuv.ready  = advance_s1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_mode_q <= 1'b0;
		end else if (cfg_we) begin
			colour_mode_q <= cfg_wdata;
		end
	end

	yrp_chroma #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_chroma (
		.u            (yuv.packed_word[7:0]),
		.v            (yuv.packed_word[23:16]),
		.chroma_red   (chroma_red),
		.chroma_green (chroma_green),
		.chroma_blue  (chroma_blue)
	);

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= yuv.valid;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (advance_s1 && yuv.valid) begin
			mode_s1     <= colour_mode_q;
			y_first_s1  <= yuv.packed_word[15:8];
			y_second_s1 <= yuv.packed_word[31:24];
			cr_s1       <= chroma_red;
			cg_s1       <= chroma_green;
			cb_s1       <= chroma_blue;
		end
	end

	yrp_lane #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_lane_first (
		.luma         (y_first_s1),
		.colour_mode  (mode_s1),
		.chroma_red   (cr_s1),
		.chroma_green (cg_s1),
		.chroma_blue  (cb_s1),
		.pixel        (first_pixel)
	);

	yrp_lane #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_lane_second (
		.luma         (y_second_s1),
		.colour_mode  (mode_s1),
		.chroma_red   (cr_s1),
		.chroma_green (cg_s1),
		.chroma_blue  (cb_s1),
		.pixel        (second_pixel)
	);

	// stage two valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// merge both lanes into the output register
	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			first_s2  <= first_pixel;
			second_s2 <= second_pixel;
		end
	end

	assign rgb.valid        = valid_s2;
	assign rgb.red_first    = first_s2.red;
	assign rgb.green_first  = first_s2.green;
	assign rgb.blue_first   = first_s2.blue;
	assign rgb.red_second   = second_s2.red;
	assign rgb.green_second = second_s2.green;
	assign rgb.blue_second  = second_s2.blue;
endmodule

// File: rtl/yrp_checker.sv
module yrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [47:0] out_payload
);
	logic [1:0] pending_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	// requests accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (in_take && !out_take) begin
			pending_q <= pending_q + 2'd1;
		end else if (out_take && !in_take) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	// no result without an earlier request
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without a pending request");

	// at most two requests in flight
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more requests in flight than stages");

	// a full pipeline must present a result
	a_full_shows: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without an output stall");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("stalled result changed");
endmodule

bind yuyv_to_rgb_pair_core yrp_checker u_yrp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (yuv.valid),
	.in_ready    (yuv.ready),
	.out_valid   (rgb.valid),
	.out_ready   (rgb.ready),
	.out_payload ({rgb.red_first, rgb.green_first, rgb.blue_first,
		rgb.red_second, rgb.green_second, rgb.blue_second})
);
